// ===== hdl/rgbwc_pkg.sv =====
// Shared constants, types and codes of the RGB window convolution block.
package rgbwc_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int RING_ROWS  = 6;
    localparam int GRID       = 5;
    localparam int TAPS       = GRID * GRID;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = $clog2(RING_ROWS * MAX_WIDTH);
    localparam int SUM_W      = 22;
    localparam int WSUM_W     = 13;
    localparam int NUM_W      = 21;
    localparam int DEN_W      = 12;

    typedef logic [7:0] t_pixel_chan;
    typedef logic signed [7:0] t_coef;

    typedef enum logic [0:0] {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_RADIUS = 3'd2,
        CFG_COEF0  = 3'd3,
        CFG_COEF1  = 3'd4,
        CFG_COEF2  = 3'd5,
        CFG_COEF3  = 3'd6
    } t_cfg_index;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MAC   = 5'b00010,
        ST_FLUSH = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_HOLD  = 5'b10000
    } t_state;

endpackage

// ===== hdl/rgbwc_coef_cell.sv =====
// One coefficient cell of the rotating coefficient chain.
module rgbwc_coef_cell (
    input  logic            i_clk,
    input  logic            i_load,
    input  logic            i_shift,
    input  rgbwc_pkg::t_coef i_load_val,
    input  rgbwc_pkg::t_coef i_next,
    output rgbwc_pkg::t_coef o_val
);
    import rgbwc_pkg::*;

    t_coef r_val;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_val <= i_load_val;
        end else if (i_shift) begin
            r_val <= i_next;
        end
    end

    assign o_val = r_val;
endmodule

// ===== hdl/rgbwc_mac.sv =====
// Three-channel multiply-accumulate unit with coefficient sum.
module rgbwc_mac (
    input  logic                                 i_clk,
    input  logic                                 i_clear,
    input  logic                                 i_vld,
    input  logic [23:0]                          i_pix,
    input  rgbwc_pkg::t_coef                     i_coef,
    output logic signed [rgbwc_pkg::SUM_W-1:0]   o_sum_b,
    output logic signed [rgbwc_pkg::SUM_W-1:0]   o_sum_g,
    output logic signed [rgbwc_pkg::SUM_W-1:0]   o_sum_r,
    output logic signed [rgbwc_pkg::WSUM_W-1:0]  o_wsum
);
    import rgbwc_pkg::*;

    logic signed [SUM_W-1:0]  r_sum_b, r_sum_g, r_sum_r;
    logic signed [WSUM_W-1:0] r_wsum;
    logic signed [16:0]       w_pb, w_pg, w_pr;

    assign w_pb = $signed({1'b0, i_pix[7:0]}) * i_coef;
    assign w_pg = $signed({1'b0, i_pix[15:8]}) * i_coef;
    assign w_pr = $signed({1'b0, i_pix[23:16]}) * i_coef;

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_sum_b <= '0;
            r_sum_g <= '0;
            r_sum_r <= '0;
            r_wsum  <= '0;
        end else if (i_vld) begin
            r_sum_b <= r_sum_b + SUM_W'(w_pb);
            r_sum_g <= r_sum_g + SUM_W'(w_pg);
            r_sum_r <= r_sum_r + SUM_W'(w_pr);
            r_wsum  <= r_wsum + WSUM_W'(i_coef);
        end
    end

    assign o_sum_b = r_sum_b;
    assign o_sum_g = r_sum_g;
    assign o_sum_r = r_sum_r;
    assign o_wsum  = r_wsum;
endmodule

// ===== hdl/rgbwc_div.sv =====
// Restoring divider giving an 8-bit quotient that saturates at 255.
module rgbwc_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [rgbwc_pkg::NUM_W-1:0]     i_num,
    input  logic [rgbwc_pkg::DEN_W-1:0]     i_den,
    output logic [7:0]                      o_quo,
    output logic                            o_done
);
    import rgbwc_pkg::*;

    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [7:0]       r_low;
    logic [7:0]       r_q;
    logic             r_sat;
    logic [3:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   w_trial;

    assign w_trial = {r_rem, r_low[7]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd8;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sat <= i_num >= {1'b0, i_den, 8'd0};
            r_rem <= i_num[DEN_W+7:8];
            r_low <= i_num[7:0];
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_low <= {r_low[6:0], 1'b0};
            if (w_trial >= {1'b0, r_den}) begin
                r_rem <= DEN_W'(w_trial - {1'b0, r_den});
                r_q   <= {r_q[6:0], 1'b1};
            end else begin
                r_rem <= w_trial[DEN_W-1:0];
                r_q   <= {r_q[6:0], 1'b0};
            end
        end
    end

    assign o_quo  = r_sat ? 8'd255 : r_q;
    assign o_done = r_done;
endmodule

// ===== hdl/rgb_window_convolution.sv =====
// Top level of the RGB window convolution block.
//
// Pixels enter in raster order, one item per cycle while the block is idle. Once the
// window of an output position is complete, the item that completes it starts the
// filter run. A chain of 25 coefficient cells rotates past a single line-store read
// port, one window tap per cycle. Every filtered pixel therefore holds the input through
// the accepting cycle, the tap reads, the flush of the tap pipeline, the divider run
// and the load of the output register, since the line store has only one read port.
// While a previous result still waits on the output, a finished run waits as well.
// Drain items after the image end push out the remaining pixels. New register values
// take effect at the first pixel of the next image.
module rgb_window_convolution (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // blue_in, green_in, red_in
    input  logic [0:0]  i_s_axis_tuser,   // operation
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // blue_out, green_out, red_out
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import rgbwc_pkg::*;

    // Configuration registers.
    logic [11:0] r_cfg_w;
    logic [12:0] r_cfg_h;
    logic [1:0]  r_cfg_r;
    logic [63:0] r_cfg_c0, r_cfg_c1, r_cfg_c2;
    logic [7:0]  r_cfg_c3;

    // Geometry of the running image.
    logic [11:0] r_act_w;
    logic [12:0] r_act_h;
    logic        r_act_r2;
    logic [12:0] r_act_lat;

    logic [COL_W-1:0] r_in_col;
    logic [ROW_W-1:0] r_in_row;
    logic [2:0]       r_in_rmod;
    logic [23:0]      r_pix_cnt;
    logic             r_in_done;
    logic [COL_W-1:0] r_out_col;
    logic [ROW_W-1:0] r_out_row;
    logic [2:0]       r_out_rmod;

    t_state     r_state;
    logic [2:0] r_ky, r_kx;
    logic       r_flush;
    logic       r_tap_vld;
    t_coef      r_tap_coef;
    logic [23:0] r_rd_data;
    logic [23:0] r_mem [RING_ROWS*MAX_WIDTH];

    logic        r_out_vld;
    logic [23:0] r_out_data;
    logic        r_out_last;

    logic w_in_acc, w_first, w_is_pixel, w_start_emit;
    logic [11:0] w_cl_w, w_use_w;
    logic [12:0] w_cl_h, w_use_h;
    logic        w_cl_r2;
    logic [12:0] w_use_lat;
    logic [11:0] w_col_inc;
    logic [12:0] w_row_inc;
    logic [23:0] w_cnt_inc;

    logic [199:0] w_coef_flat;
    t_coef        w_cell [TAPS];
    logic         w_coef_load, w_coef_shift;

    logic signed [13:0] w_px, w_py;
    logic [COL_W-1:0]   w_px_cl;
    logic [ROW_W:0]     w_py_cl;
    logic [3:0]         w_rsum;
    logic [3:0]         w_rtmp;
    logic [2:0]         w_rsel;
    logic               w_mask;
    logic [ADDR_W-1:0]  w_raddr;

    logic signed [SUM_W-1:0]  w_sum_b, w_sum_g, w_sum_r;
    logic signed [WSUM_W-1:0] w_wsum;
    logic [DEN_W-1:0]         w_den;
    logic [7:0]  w_q_b, w_q_g, w_q_r;
    logic        w_done_b, w_done_g, w_done_r;
    logic        w_div_start, w_load_out, w_last;
    logic [11:0] w_ocol_inc;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_is_pixel      = (i_s_axis_tuser == OP_PIXEL);
    assign w_first         = (r_pix_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w  <= 12'd640;
            r_cfg_h  <= 13'd480;
            r_cfg_r  <= 2'd1;
            r_cfg_c0 <= 64'd1157425104234217472;
            r_cfg_c1 <= 64'd17661173956624;
            r_cfg_c2 <= 64'd1052688;
            r_cfg_c3 <= 8'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_cfg_w  <= i_cfg_data[11:0];
                CFG_HEIGHT: r_cfg_h  <= i_cfg_data[12:0];
                CFG_RADIUS: r_cfg_r  <= i_cfg_data[1:0];
                CFG_COEF0:  r_cfg_c0 <= i_cfg_data;
                CFG_COEF1:  r_cfg_c1 <= i_cfg_data;
                CFG_COEF2:  r_cfg_c2 <= i_cfg_data;
                CFG_COEF3:  r_cfg_c3 <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_cl_w = r_cfg_w;
        if (r_cfg_w == '0) begin
            w_cl_w = 12'd1;
        end else if (r_cfg_w > 12'(MAX_WIDTH)) begin
            w_cl_w = 12'(MAX_WIDTH);
        end
        w_cl_h = r_cfg_h;
        if (r_cfg_h == '0) begin
            w_cl_h = 13'd1;
        end else if (r_cfg_h > 13'(MAX_HEIGHT)) begin
            w_cl_h = 13'(MAX_HEIGHT);
        end
        w_cl_r2   = r_cfg_r[1];
        w_use_w   = w_first ? w_cl_w : r_act_w;
        w_use_h   = w_first ? w_cl_h : r_act_h;
        w_use_lat = w_first ? (w_cl_r2 ? 13'({w_cl_w, 1'b0}) + 13'd2 : 13'(w_cl_w) + 13'd1)
                            : r_act_lat;
        w_col_inc = 12'(r_in_col) + 12'd1;
        w_row_inc = 13'(r_in_row) + 13'd1;
        w_cnt_inc = r_pix_cnt + 24'd1;
    end

    assign w_start_emit = w_in_acc && (w_is_pixel
                          ? (!r_in_done && (w_cnt_inc > 24'(w_use_lat))) : r_in_done);

    // Window tap address with clamp-to-edge.
    always_comb begin
        w_px = $signed({3'b0, r_out_col}) + $signed({11'b0, r_kx}) - 14'sd2;
        w_py = $signed({2'b0, r_out_row}) + $signed({11'b0, r_ky}) - 14'sd2;
        if (w_px < 0) begin
            w_px_cl = '0;
        end else if (w_px >= $signed({2'b0, r_act_w})) begin
            w_px_cl = COL_W'(r_act_w - 12'd1);
        end else begin
            w_px_cl = w_px[COL_W-1:0];
        end
        if (w_py < 0) begin
            w_py_cl = '0;
        end else if (w_py >= $signed({1'b0, r_act_h})) begin
            w_py_cl = r_act_h - 13'd1;
        end else begin
            w_py_cl = w_py[ROW_W:0];
        end
        w_rsum = 4'(r_out_rmod) + 4'(w_py_cl + 13'd2 - 13'(r_out_row));
        w_rtmp = w_rsum + 4'd4;
        if (w_rtmp >= 4'd12) begin
            w_rtmp = w_rtmp - 4'd12;
        end else if (w_rtmp >= 4'd6) begin
            w_rtmp = w_rtmp - 4'd6;
        end
        w_rsel  = w_rtmp[2:0];
        w_mask  = r_act_r2 || (r_ky >= 3'd1 && r_ky <= 3'd3 && r_kx >= 3'd1 && r_kx <= 3'd3);
        w_raddr = {w_rsel, w_px_cl};
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_is_pixel && !r_in_done) begin
            r_mem[{r_in_rmod, r_in_col}] <= i_s_axis_tdata;
        end
        r_rd_data <= r_mem[w_raddr];
    end

    // Rotating coefficient chain.
    assign w_coef_flat  = {r_cfg_c3, r_cfg_c2, r_cfg_c1, r_cfg_c0};
    assign w_coef_load  = w_in_acc && w_is_pixel && w_first && !r_in_done;
    assign w_coef_shift = (r_state == ST_MAC);

    for (genvar g = 0; g < TAPS; g++) begin : g_cell
        rgbwc_coef_cell u_cell (
            .i_clk      (i_clk),
            .i_load     (w_coef_load),
            .i_shift    (w_coef_shift),
            .i_load_val (w_coef_flat[8*g +: 8]),
            .i_next     (w_cell[(g + 1) % TAPS]),
            .o_val      (w_cell[g])
        );
    end

    always_ff @(posedge i_clk) begin
        r_tap_coef <= w_mask ? w_cell[0] : 8'sd0;
    end

    rgbwc_mac u_mac (
        .i_clk   (i_clk),
        .i_clear (w_start_emit),
        .i_vld   (r_tap_vld),
        .i_pix   (r_rd_data),
        .i_coef  (r_tap_coef),
        .o_sum_b (w_sum_b),
        .o_sum_g (w_sum_g),
        .o_sum_r (w_sum_r),
        .o_wsum  (w_wsum)
    );

    assign w_div_start = (r_state == ST_FLUSH) && r_flush;
    assign w_den       = (w_wsum > 0) ? w_wsum[DEN_W-1:0] : DEN_W'(16);

    rgbwc_div u_div_b (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_div_start),
        .i_num ((w_sum_b > 0) ? w_sum_b[NUM_W-1:0] : '0), .i_den (w_den),
        .o_quo (w_q_b), .o_done (w_done_b)
    );
    rgbwc_div u_div_g (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_div_start),
        .i_num ((w_sum_g > 0) ? w_sum_g[NUM_W-1:0] : '0), .i_den (w_den),
        .o_quo (w_q_g), .o_done (w_done_g)
    );
    rgbwc_div u_div_r (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (w_div_start),
        .i_num ((w_sum_r > 0) ? w_sum_r[NUM_W-1:0] : '0), .i_den (w_den),
        .o_quo (w_q_r), .o_done (w_done_r)
    );

    assign w_load_out = (r_state == ST_HOLD) && (!r_out_vld || i_m_axis_tready);
    assign w_last     = (12'(r_out_col) == r_act_w - 12'd1)
                        && (13'(r_out_row) == r_act_h - 13'd1);
    assign w_ocol_inc = 12'(r_out_col) + 12'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ky      <= '0;
            r_kx      <= '0;
            r_flush   <= 1'b0;
            r_tap_vld <= 1'b0;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_in_rmod <= '0;
            r_pix_cnt <= '0;
            r_in_done <= 1'b0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_out_rmod <= '0;
            r_out_vld <= 1'b0;
            r_act_w   <= 12'd640;
            r_act_h   <= 13'd480;
            r_act_r2  <= 1'b0;
            r_act_lat <= 13'd641;
        end else begin
            r_tap_vld <= (r_state == ST_MAC);
            if (w_load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && w_is_pixel && !r_in_done) begin
                        if (w_first) begin
                            r_act_w   <= w_cl_w;
                            r_act_h   <= w_cl_h;
                            r_act_r2  <= w_cl_r2;
                            r_act_lat <= w_use_lat;
                        end
                        r_pix_cnt <= w_cnt_inc;
                        if (w_col_inc >= w_use_w) begin
                            r_in_col  <= '0;
                            r_in_row  <= w_row_inc[ROW_W-1:0];
                            r_in_rmod <= (r_in_rmod == 3'(RING_ROWS - 1)) ? 3'd0
                                                                          : r_in_rmod + 3'd1;
                            if (w_row_inc >= w_use_h) begin
                                r_in_done <= 1'b1;
                            end
                        end else begin
                            r_in_col <= w_col_inc[COL_W-1:0];
                        end
                    end
                    if (w_start_emit) begin
                        r_state <= ST_MAC;
                        r_ky    <= '0;
                        r_kx    <= '0;
                    end
                end
                ST_MAC: begin
                    if (r_kx == 3'(GRID - 1)) begin
                        r_kx <= '0;
                        if (r_ky == 3'(GRID - 1)) begin
                            r_state <= ST_FLUSH;
                            r_flush <= 1'b0;
                        end else begin
                            r_ky <= r_ky + 3'd1;
                        end
                    end else begin
                        r_kx <= r_kx + 3'd1;
                    end
                end
                ST_FLUSH: begin
                    r_flush <= 1'b1;
                    if (r_flush) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_done_b) begin
                        r_state <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (w_load_out) begin
                        r_state   <= ST_IDLE;
                        if (w_last) begin
                            r_in_col   <= '0;
                            r_in_row   <= '0;
                            r_in_rmod  <= '0;
                            r_pix_cnt  <= '0;
                            r_in_done  <= 1'b0;
                            r_out_col  <= '0;
                            r_out_row  <= '0;
                            r_out_rmod <= '0;
                        end else if (w_ocol_inc >= r_act_w) begin
                            r_out_col  <= '0;
                            r_out_row  <= r_out_row + ROW_W'(1);
                            r_out_rmod <= (r_out_rmod == 3'(RING_ROWS - 1)) ? 3'd0
                                                                            : r_out_rmod + 3'd1;
                        end else begin
                            r_out_col <= w_ocol_inc[COL_W-1:0];
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data <= {w_q_r, w_q_g, w_q_b};
            r_out_last <= w_last;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register is not one-hot");

    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_out && w_last) |=> (r_pix_cnt == '0 && !r_in_done))
        else $error("image counters not cleared after the final item");

    a_div_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done_b |-> (w_done_g && w_done_r && r_state == ST_DIV))
        else $error("dividers out of step");
endmodule
